### src/sat_pkg.sv
// Shared types and constants of the segment address translator.
`default_nettype none

package sat_pkg;

    // Item opcodes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_XLATE = 1'b1;

    // Configuration register map
    localparam int  CFG_ADDR_W  = 3;
    localparam logic REG_MAX_SEG = 1'b0;
    localparam logic [15:0] MAX_SEG_RESET = 16'd64;

    // Serial divider
    localparam int DIV_CNT_W = 5;
    localparam logic [DIV_CNT_W-1:0] DIV_LAST_STEP = 5'd31;

    typedef struct packed {
        logic        opcode;
        logic [3:0]  slot_index;
        logic        entry_valid;
        logic [15:0] segment_id;
        logic [31:0] segment_base;
        logic [15:0] segment_size;
        logic [31:0] logical_address;
        logic [15:0] access_length;
    } item_t;

    typedef struct packed {
        logic [31:0] physical_address;
        logic        xlate_fault;
        logic [31:0] segment_number;
        logic [15:0] segment_offset;
    } result_t;

    // One table slot as stored in the RAM
    typedef struct packed {
        logic [15:0] id;
        logic [31:0] base;
        logic [15:0] size;
    } entry_t;

endpackage

`default_nettype wire

### src/sat_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module sat_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  wire logic                                   clk,
    input  wire logic                                   we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                       wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output      logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

`default_nettype wire

### src/segment_address_translator_top.sv
// Top level of the segment address translator: sequencer, serial divider, table scan.
//
//  channel   | direction | handshake                  | payload
//  ----------+-----------+----------------------------+----------------------------
//  command   | in        | start && !busy             | item   (sat_pkg::item_t)
//  result    | out       | done, one cycle            | result (sat_pkg::result_t)
//  config    | in/out    | psel & penable (pready=1)  | paddr, pwdata, prdata
//
//  A table write answers with its all-zero word on the next cycle.
//  A translation runs the 1-bit-per-cycle restoring divider, then the table scan
//  (one RAM read per cycle, stopping at the first valid match or the last slot),
//  then a resolve step. A zero divisor skips division and scan and goes to resolve.
//  Reset clears the valid marks and sets max_segment_size to 64.
//  The receiver cannot stall; busy only reflects the sequencer.
`default_nettype none

module segment_address_translator_top #(
    parameter int TABLE_ENTRIES = 16
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    output      logic                            busy,
    input  wire sat_pkg::item_t                  item,
    output      logic                            done,
    output      sat_pkg::result_t                result,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [sat_pkg::CFG_ADDR_W-1:0]  paddr,
    input  wire logic [31:0]                     pwdata,
    output      logic [31:0]                     prdata,
    output      logic                            pready
);

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);
    localparam int ENTRY_W = $bits(sat_pkg::entry_t);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_SCAN,
        S_RESOLVE
    } state_t;

    // ---------------- configuration port ----------------
    logic [15:0] max_seg_reg;
    logic        cfg_sel;

    assign pready  = 1'b1;
    assign cfg_sel = (paddr[2] == sat_pkg::REG_MAX_SEG);
    assign prdata  = cfg_sel ? {16'd0, max_seg_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_seg_reg <= sat_pkg::MAX_SEG_RESET;
        end
        else if (psel && penable && pwrite && cfg_sel)
        begin
            max_seg_reg <= pwdata[15:0];
        end
    end

    // ---------------- table storage ----------------
    logic                    accept;
    logic                    wr_en;
    logic [IDX_W+3:0]        slot_ext;
    logic [IDX_W-1:0]        waddr;
    sat_pkg::entry_t         wr_entry;
    logic [ENTRY_W-1:0]      ram_rdata;
    sat_pkg::entry_t         rd_entry;

    assign accept   = start && !busy;
    assign wr_en    = accept && (item.opcode == sat_pkg::OP_WRITE)
                      && (int'(item.slot_index) < TABLE_ENTRIES);
    assign slot_ext = {{IDX_W{1'b0}}, item.slot_index};
    assign waddr    = slot_ext[IDX_W-1:0];
    assign wr_entry = '{id: item.segment_id, base: item.segment_base,
                        size: item.segment_size};
    assign rd_entry = sat_pkg::entry_t'(ram_rdata);

    // ---------------- sequencer ----------------
    state_t                      state_reg,     state_next;
    logic                        valid_reg      [TABLE_ENTRIES];
    logic                        done_reg,      done_next;
    sat_pkg::result_t            result_reg,    result_next;
    logic [31:0]                 quot_reg,      quot_next;
    logic [15:0]                 rem_reg,       rem_next;
    logic [15:0]                 len_reg,       len_next;
    logic [sat_pkg::DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;
    logic                        zero_div_reg,  zero_div_next;
    logic [IDX_W-1:0]            scan_cnt_reg,  scan_cnt_next;
    logic                        issued_reg,    issued_next;
    logic                        pend_reg,      pend_next;
    logic                        pend_vld_reg,  pend_vld_next;
    logic [IDX_W-1:0]            chk_idx_reg,   chk_idx_next;
    logic                        hit_reg,       hit_next;
    logic [31:0]                 base_reg,      base_next;
    logic [15:0]                 size_reg,      size_next;

    logic [16:0]                 trial;
    logic                        take;
    logic                        match;
    logic [16:0]                 span;
    logic                        fault;

    sat_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .clk   (clk),
        .we    (wr_en),
        .waddr (waddr),
        .wdata (wr_entry),
        .raddr (scan_cnt_reg),
        .rdata (ram_rdata)
    );

    assign trial = {rem_reg, quot_reg[31]};
    assign take  = (trial >= {1'b0, max_seg_reg});
    assign match = pend_vld_reg && ({16'd0, rd_entry.id} == quot_reg);
    assign span  = {1'b0, rem_reg} + {1'b0, len_reg};
    assign fault = zero_div_reg || !hit_reg || (span > {1'b0, size_reg});

    always_comb
    begin
        state_next    = state_reg;
        done_next     = 1'b0;
        result_next   = result_reg;
        quot_next     = quot_reg;
        rem_next      = rem_reg;
        len_next      = len_reg;
        div_cnt_next  = div_cnt_reg;
        zero_div_next = zero_div_reg;
        scan_cnt_next = scan_cnt_reg;
        issued_next   = issued_reg;
        pend_next     = 1'b0;
        pend_vld_next = pend_vld_reg;
        chk_idx_next  = chk_idx_reg;
        hit_next      = hit_reg;
        base_next     = base_reg;
        size_next     = size_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (item.opcode == sat_pkg::OP_WRITE)
                    begin
                        done_next   = 1'b1;
                        result_next = '0;
                    end
                    else
                    begin
                        quot_next     = item.logical_address;
                        rem_next      = 16'd0;
                        len_next      = item.access_length;
                        div_cnt_next  = sat_pkg::DIV_LAST_STEP;
                        hit_next      = 1'b0;
                        zero_div_next = (max_seg_reg == 16'd0);
                        state_next    = (max_seg_reg == 16'd0) ? S_RESOLVE : S_DIV;
                    end
                end
            end
            S_DIV:
            begin
                // one restoring step: shift in the next dividend bit
                rem_next  = take ? 16'(trial - {1'b0, max_seg_reg}) : trial[15:0];
                quot_next = {quot_reg[30:0], take};
                if (div_cnt_reg == '0)
                begin
                    scan_cnt_next = '0;
                    issued_next   = 1'b0;
                    state_next    = S_SCAN;
                end
                else
                begin
                    div_cnt_next = div_cnt_reg - 1'b1;
                end
            end
            S_SCAN:
            begin
                // issue one slot read per cycle, check it on the next cycle
                if (!issued_reg)
                begin
                    pend_next     = 1'b1;
                    pend_vld_next = valid_reg[scan_cnt_reg];
                    chk_idx_next  = scan_cnt_reg;
                    if (scan_cnt_reg == LAST_IDX)
                    begin
                        issued_next = 1'b1;
                    end
                    else
                    begin
                        scan_cnt_next = scan_cnt_reg + 1'b1;
                    end
                end
                if (pend_reg && (match || (chk_idx_reg == LAST_IDX)))
                begin
                    hit_next   = match;
                    base_next  = rd_entry.base;
                    size_next  = rd_entry.size;
                    pend_next  = 1'b0;
                    state_next = S_RESOLVE;
                end
            end
            S_RESOLVE:
            begin
                done_next = 1'b1;
                if (zero_div_reg)
                begin
                    result_next.physical_address = 32'd0;
                    result_next.xlate_fault      = 1'b1;
                    result_next.segment_number   = 32'hFFFF_FFFF;
                    result_next.segment_offset   = 16'd0;
                end
                else
                begin
                    result_next.physical_address = fault ? 32'd0
                                                   : base_reg + {16'd0, rem_reg};
                    result_next.xlate_fault      = fault;
                    result_next.segment_number   = quot_reg;
                    result_next.segment_offset   = rem_reg;
                end
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            done_reg   <= 1'b0;
            result_reg <= '0;
            pend_reg   <= 1'b0;
            for (int i = 0; i < TABLE_ENTRIES; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
        end
        else
        begin
            state_reg  <= state_next;
            done_reg   <= done_next;
            result_reg <= result_next;
            pend_reg   <= pend_next;
            if (wr_en)
            begin
                valid_reg[waddr] <= item.entry_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg     <= quot_next;
        rem_reg      <= rem_next;
        len_reg      <= len_next;
        div_cnt_reg  <= div_cnt_next;
        zero_div_reg <= zero_div_next;
        scan_cnt_reg <= scan_cnt_next;
        issued_reg   <= issued_next;
        pend_vld_reg <= pend_vld_next;
        chk_idx_reg  <= chk_idx_next;
        hit_reg      <= hit_next;
        base_reg     <= base_next;
        size_reg     <= size_next;
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

### src/sat_checker.sv
// Port-level checks of the segment address translator, bound to the top level.
`default_nettype none

module sat_checker (
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             start,
    input wire logic             busy,
    input wire sat_pkg::item_t   item,
    input wire logic             done,
    input wire sat_pkg::result_t result
);

    // a table write answers on the next cycle with an all-zero word
    a_write_word: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (item.opcode == sat_pkg::OP_WRITE)
        |=> done && (result == '0))
        else $error("write item did not return a zero word next cycle");

    // a translation holds the block busy
    a_xlate_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (item.opcode == sat_pkg::OP_XLATE) |=> busy && !done)
        else $error("translation did not hold busy");

    // a word never shows while the sequencer is still working
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    // a fault never carries an address
    a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.xlate_fault |-> (result.physical_address == 32'd0))
        else $error("faulted word carries a physical address");

    // the end of a translation always brings its word
    a_busy_end: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("translation ended without a result");

endmodule

bind segment_address_translator_top sat_checker u_sat_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .item   (item),
    .done   (done),
    .result (result)
);

`default_nettype wire
